// ===== hw/rtl/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// TVD slope limiter package
// Shared widths, register indexes, limiter codes and fixed-point constants.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int DW         = 32;   // cell value width
  localparam int DIFF_W     = 33;   // exact difference width
  localparam int SL_W       = 34;   // biased slope width
  localparam int PHI_W      = 16;   // limiter value, unsigned Q2.14
  localparam int BIAS_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Ratio divider: one quotient bit per stage, bits 30 down to 0.
  localparam int RQ_W   = 31;
  localparam int RSTEPS = RQ_W;
  // Reciprocal dividers: fifteen quotient bits, one per stage.
  localparam int QW     = 47;
  localparam int QSTEPS = 15;

  localparam int SDLY = RSTEPS - 2;          // slope delay to meet the ratio
  localparam int NSTG = RSTEPS + QSTEPS + 7; // total register stages

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 8'd1;

  localparam logic [MODE_W-1:0] MODE_SUPERBEE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VANLEER  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MINBEE   = 2'd2;

  localparam logic [PHI_W-1:0] Q_HALF = 16'd8192;
  localparam logic [PHI_W-1:0] Q_ONE  = 16'd16384;
  localparam logic [PHI_W-1:0] Q_TWO  = 16'd32768;
  localparam logic [RQ_W-1:0]  R_LIMIT = 31'd1073741824;
  localparam logic [QW-1:0]    XI_CAP_D = 47'd268435456;  // 2^28

endpackage

// ===== hw/rtl/tsl_if.sv =====
// ----------------------------------------------------------------------------
// TVD slope limiter channels
// Valid/ready channels for cell values, limiter results and register writes.
// ----------------------------------------------------------------------------
interface tsl_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [tsl_pkg::DW-1:0]   left_value;
  logic signed [tsl_pkg::DW-1:0]   middle_value;
  logic signed [tsl_pkg::DW-1:0]   right_value;
  modport source (output valid, left_value, middle_value, right_value, input ready);
  modport sink   (input valid, left_value, middle_value, right_value, output ready);
endinterface

interface tsl_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [tsl_pkg::DW-1:0]   limited_slope;
  logic [tsl_pkg::PHI_W-1:0]       limiter_value;
  logic                            saturated;
  modport source (output valid, limited_slope, limiter_value, saturated, input ready);
  modport sink   (input valid, limited_slope, limiter_value, saturated, output ready);
endinterface

interface tsl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tsl_pkg::CFG_IDX_W-1:0]     index;
  logic [tsl_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tsl_rdiv.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Pipelined restoring divider for |dl| * 2^14 / |dr|, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tsl_rdiv (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tsl_pkg::DIFF_W-1:0]        an,
  input  logic [tsl_pkg::DIFF_W-1:0]        ad,
  input  logic                              neg,
  output logic [tsl_pkg::RQ_W-1:0]          q,
  output logic                              ovf,
  output logic                              neg_o
);

  logic [tsl_pkg::DIFF_W-1:0] rem_r [tsl_pkg::RSTEPS];
  logic [tsl_pkg::DIFF_W-1:0] den_r [tsl_pkg::RSTEPS];
  logic [tsl_pkg::DIFF_W-1:0] an_r  [tsl_pkg::RSTEPS];
  logic [tsl_pkg::RQ_W-1:0]   q_r   [tsl_pkg::RSTEPS];
  logic                       ovf_r [tsl_pkg::RSTEPS];
  logic                       neg_r [tsl_pkg::RSTEPS];

  // The quotient fits in 31 bits unless |dl| >> 17 is not below |dr|.
  logic [tsl_pkg::DIFF_W-1:0] rem0;
  logic                       ovf0;
  assign rem0 = {17'd0, an[32:17]};
  assign ovf0 = rem0 >= ad;

  for (genvar k = 0; k < tsl_pkg::RSTEPS; k++) begin : g_stage
    localparam int BIT = tsl_pkg::RSTEPS - 1 - k;
    logic [tsl_pkg::DIFF_W-1:0] rem_in, den_in, an_in;
    logic [tsl_pkg::RQ_W-1:0]   q_in;
    logic                       ovf_in, neg_in, nbit, ge;
    logic [tsl_pkg::DIFF_W:0]   t;

    if (k == 0) begin : g_first
      assign rem_in = rem0;
      assign den_in = ad;
      assign an_in  = an;
      assign q_in   = '0;
      assign ovf_in = ovf0;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign an_in  = an_r[k-1];
      assign q_in   = q_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign neg_in = neg_r[k-1];
    end

    // Numerator bit BIT of |dl| * 2^14.
    if (BIT >= 14) begin : g_nbit
      assign nbit = an_in[BIT-14];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign t  = {rem_in, nbit};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? tsl_pkg::DIFF_W'(t - {1'b0, den_in}) : t[tsl_pkg::DIFF_W-1:0];
        den_r[k] <= den_in;
        an_r[k]  <= an_in;
        q_r[k]   <= {q_in[tsl_pkg::RQ_W-2:0], ge};
        ovf_r[k] <= ovf_in;
        neg_r[k] <= neg_in;
      end
    end
  end

  assign q     = q_r[tsl_pkg::RSTEPS-1];
  assign ovf   = ovf_r[tsl_pkg::RSTEPS-1];
  assign neg_o = neg_r[tsl_pkg::RSTEPS-1];

endmodule

// ===== hw/rtl/tsl_qdiv.sv =====
// ----------------------------------------------------------------------------
// Fraction divider
// Pipelined restoring divider giving fifteen quotient bits of rem0 / den,
// where rem0 < den and the dividend continues with zero bits.
// ----------------------------------------------------------------------------
module tsl_qdiv (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tsl_pkg::QW-1:0]     rem0,
  input  logic [tsl_pkg::QW-1:0]     den,
  output logic [tsl_pkg::QSTEPS-1:0] q
);

  logic [tsl_pkg::QW-1:0]     rem_r [tsl_pkg::QSTEPS];
  logic [tsl_pkg::QW-1:0]     den_r [tsl_pkg::QSTEPS];
  logic [tsl_pkg::QSTEPS-1:0] q_r   [tsl_pkg::QSTEPS];

  for (genvar k = 0; k < tsl_pkg::QSTEPS; k++) begin : g_stage
    logic [tsl_pkg::QW-1:0]     rem_in, den_in;
    logic [tsl_pkg::QSTEPS-1:0] q_in;
    logic [tsl_pkg::QW:0]       t;
    logic                       ge;

    if (k == 0) begin : g_first
      assign rem_in = rem0;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign t  = {rem_in, 1'b0};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? tsl_pkg::QW'(t - {1'b0, den_in}) : t[tsl_pkg::QW-1:0];
        den_r[k] <= den_in;
        q_r[k]   <= {q_in[tsl_pkg::QSTEPS-2:0], ge};
      end
    end
  end

  assign q = q_r[tsl_pkg::QSTEPS-1];

endmodule

// ===== hw/rtl/tvd_slope_limiter.sv =====
// ----------------------------------------------------------------------------
// TVD slope limiter
// Biased slope, saturated ratio and Super-Bee, Van-Leer or Min-Bee limiter.
// ----------------------------------------------------------------------------
// The block takes one beat of three cell values per clock and returns one
// beat of limited slope, limiter value and saturation flag per clock while
// the output is not stalled. The pipeline has 53 register stages: the two
// divider pipelines take 31 stages for the ratio of the differences and 15
// for the reciprocal terms, plus the stages for the slope and limiter
// products. A stalled output holds the whole pipeline. Register writes
// must be made while the block is idle.
module tvd_slope_limiter (
  input  logic       clk,
  input  logic       rst_n,
  tsl_in_if.sink     in_ch,
  tsl_out_if.source  out_ch,
  tsl_cfg_if.sink    cfg_ch
);

  localparam int N = tsl_pkg::NSTG;

  logic signed [tsl_pkg::BIAS_W-1:0] bias_r;
  logic [tsl_pkg::MODE_W-1:0]        mode_r;
  logic [N-1:0]                      v_r;
  logic                              adv, in_fire;

  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      mode_r <= tsl_pkg::MODE_SUPERBEE;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == tsl_pkg::CFG_BIAS) begin
        bias_r <= cfg_ch.data;
      end else if (cfg_ch.index == tsl_pkg::CFG_MODE) begin
        mode_r <= cfg_ch.data[tsl_pkg::MODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N-2:0], in_fire};
    end
  end

  // Clamped bias and the weights 1+w and 1-w in Q2.14.
  logic signed [tsl_pkg::BIAS_W-1:0] w_c;
  logic signed [17:0]                ap, bp;
  logic [16:0]                       a17, b17;
  always_comb begin
    if (bias_r > 16'sd16384) begin
      w_c = 16'sd16384;
    end else if (bias_r < -16'sd16384) begin
      w_c = -16'sd16384;
    end else begin
      w_c = bias_r;
    end
  end
  assign ap  = 18'sd16384 + 18'(w_c);
  assign bp  = 18'sd16384 - 18'(w_c);
  assign a17 = ap[16:0];
  assign b17 = bp[16:0];

  // Stage 1: exact differences.
  logic signed [tsl_pkg::DIFF_W-1:0] dl1_r, dr1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_r <= 33'(in_ch.middle_value) - 33'(in_ch.left_value);
      dr1_r <= 33'(in_ch.right_value) - 33'(in_ch.middle_value);
    end
  end

  // Differences within one LSB count as +1 LSB in the ratio.
  logic signed [tsl_pkg::DIFF_W-1:0] num1, den1;
  logic [tsl_pkg::DIFF_W-1:0]        an1, ad1;
  logic                              neg1;
  assign num1 = (dl1_r > 33'sd1 || dl1_r < -33'sd1) ? dl1_r : 33'sd1;
  assign den1 = (dr1_r > 33'sd1 || dr1_r < -33'sd1) ? dr1_r : 33'sd1;
  assign an1  = num1[32] ? 33'(-num1) : num1;
  assign ad1  = den1[32] ? 33'(-den1) : den1;
  assign neg1 = num1[32] != den1[32];

  logic [tsl_pkg::RQ_W-1:0] rq;
  logic                     rovf, rneg;
  tsl_rdiv u_rdiv (
    .clk   (clk),
    .en    (adv),
    .an    (an1),
    .ad    (ad1),
    .neg   (neg1),
    .q     (rq),
    .ovf   (rovf),
    .neg_o (rneg)
  );

  // Stages 2 and 3: biased slope, then delay to meet the ratio.
  logic signed [50:0]              pa2_r, pb2_r;
  logic signed [tsl_pkg::SL_W-1:0] s3_r;
  logic signed [tsl_pkg::SL_W-1:0] s_ln_r [tsl_pkg::SDLY];
  logic signed [51:0]              s_sum;
  assign s_sum = 52'(pa2_r) + 52'(pb2_r) + 52'sd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa2_r <= $signed({1'b0, a17}) * dl1_r;
      pb2_r <= $signed({1'b0, b17}) * dr1_r;
      s3_r  <= tsl_pkg::SL_W'(s_sum >>> 15);
      s_ln_r[0] <= s3_r;
      for (int i = 1; i < tsl_pkg::SDLY; i++) begin
        s_ln_r[i] <= s_ln_r[i-1];
      end
    end
  end

  // Stages 33 to 35: saturated ratio, xi and Van-Leer denominators.
  logic [tsl_pkg::RQ_W-1:0]        rm33_r, rm34_r, rm35_r;
  logic                            rn33_r, rn34_r, rn35_r;
  logic                            st33_r, st34_r, st35_r;
  logic signed [tsl_pkg::SL_W-1:0] s33_r, s34_r, s35_r;
  logic [tsl_pkg::QW-1:0]          prod34_r, d35_r, e35_r, dsum;
  logic                            cap35_r;
  logic                            rsat;

  assign rsat = rovf || rq > tsl_pkg::R_LIMIT;
  assign dsum = tsl_pkg::QW'({b17, 14'd0}) + prod34_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rm33_r   <= rsat ? tsl_pkg::R_LIMIT : rq;
      rn33_r   <= rneg;
      st33_r   <= rsat;
      s33_r    <= s_ln_r[tsl_pkg::SDLY-1];
      prod34_r <= tsl_pkg::QW'(a17 * rm33_r);
      rm34_r   <= rm33_r;
      rn34_r   <= rn33_r;
      st34_r   <= st33_r;
      s34_r    <= s33_r;
      d35_r    <= dsum;
      cap35_r  <= dsum <= tsl_pkg::XI_CAP_D;
      e35_r    <= tsl_pkg::QW'(rm34_r) + tsl_pkg::QW'(tsl_pkg::Q_ONE);
      rm35_r   <= rm34_r;
      rn35_r   <= rn34_r;
      st35_r   <= st34_r;
      s35_r    <= s34_r;
    end
  end

  // Stages 36 to 50: xi = 2^43 / D and the Van-Leer term 2^15 r / (2^14 + r).
  logic [tsl_pkg::QSTEPS-1:0] xq, vq;
  tsl_qdiv u_xi (
    .clk  (clk),
    .en   (adv),
    .rem0 (cap35_r ? '0 : tsl_pkg::XI_CAP_D),
    .den  (cap35_r ? tsl_pkg::QW'(1) : d35_r),
    .q    (xq)
  );
  tsl_qdiv u_vl (
    .clk  (clk),
    .en   (adv),
    .rem0 (tsl_pkg::QW'(rm35_r)),
    .den  (e35_r),
    .q    (vq)
  );

  logic [tsl_pkg::RQ_W-1:0]        rm_ln_r  [tsl_pkg::QSTEPS];
  logic                            rn_ln_r  [tsl_pkg::QSTEPS];
  logic                            st_ln_r  [tsl_pkg::QSTEPS];
  logic                            cap_ln_r [tsl_pkg::QSTEPS];
  logic signed [tsl_pkg::SL_W-1:0] s_qln_r  [tsl_pkg::QSTEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rm_ln_r[0]  <= rm35_r;
      rn_ln_r[0]  <= rn35_r;
      st_ln_r[0]  <= st35_r;
      cap_ln_r[0] <= cap35_r;
      s_qln_r[0]  <= s35_r;
      for (int i = 1; i < tsl_pkg::QSTEPS; i++) begin
        rm_ln_r[i]  <= rm_ln_r[i-1];
        rn_ln_r[i]  <= rn_ln_r[i-1];
        st_ln_r[i]  <= st_ln_r[i-1];
        cap_ln_r[i] <= cap_ln_r[i-1];
        s_qln_r[i]  <= s_qln_r[i-1];
      end
    end
  end

  // Stage 51: limiter selection.
  localparam int L = tsl_pkg::QSTEPS - 1;
  logic [tsl_pkg::RQ_W-1:0]  rmx, xi_c, vl_c, m_a;
  logic [tsl_pkg::PHI_W-1:0] phi_nxt;
  assign rmx  = rm_ln_r[L];
  assign xi_c = cap_ln_r[L] ? tsl_pkg::RQ_W'(tsl_pkg::Q_TWO) : tsl_pkg::RQ_W'(xq);
  assign vl_c = tsl_pkg::RQ_W'(vq);

  always_comb begin
    m_a     = '0;
    phi_nxt = '0;
    if (rn_ln_r[L]) begin
      phi_nxt = '0;
    end else begin
      unique case (mode_r)
        tsl_pkg::MODE_SUPERBEE: begin
          if (rmx < tsl_pkg::RQ_W'(tsl_pkg::Q_HALF)) begin
            phi_nxt = tsl_pkg::PHI_W'({rmx, 1'b0});
          end else if (rmx < tsl_pkg::RQ_W'(tsl_pkg::Q_ONE)) begin
            phi_nxt = tsl_pkg::Q_ONE;
          end else begin
            m_a     = (rmx < xi_c) ? rmx : xi_c;
            phi_nxt = (m_a < tsl_pkg::RQ_W'(tsl_pkg::Q_TWO)) ? m_a[tsl_pkg::PHI_W-1:0]
                                                             : tsl_pkg::Q_TWO;
          end
        end
        tsl_pkg::MODE_VANLEER: begin
          m_a     = (vl_c < xi_c) ? vl_c : xi_c;
          phi_nxt = m_a[tsl_pkg::PHI_W-1:0];
        end
        default: begin
          if (rmx < tsl_pkg::RQ_W'(tsl_pkg::Q_ONE)) begin
            phi_nxt = rmx[tsl_pkg::PHI_W-1:0];
          end else begin
            phi_nxt = (xi_c < tsl_pkg::RQ_W'(tsl_pkg::Q_ONE)) ? xi_c[tsl_pkg::PHI_W-1:0]
                                                              : tsl_pkg::Q_ONE;
          end
        end
      endcase
    end
  end

  // Stages 51 to 53: product, rounding and saturation.
  logic [tsl_pkg::PHI_W-1:0]       phi51_r, phi52_r;
  logic                            st51_r, st52_r;
  logic signed [tsl_pkg::SL_W-1:0] s51_r;
  logic signed [50:0]              m52_r;
  logic signed [37:0]              lim;
  logic                            lim_hi, lim_lo;
  logic signed [tsl_pkg::DW-1:0]   slope_r;
  logic [tsl_pkg::PHI_W-1:0]       phi_o_r;
  logic                            sat_o_r;

  assign lim    = 38'((52'(m52_r) + 52'sd8192) >>> 14);
  assign lim_hi = lim > 38'sd2147483647;
  assign lim_lo = lim < -38'sd2147483648;

  always_ff @(posedge clk) begin
    if (adv) begin
      phi51_r <= phi_nxt;
      st51_r  <= st_ln_r[L];
      s51_r   <= s_qln_r[L];
      m52_r   <= s51_r * $signed({1'b0, phi51_r});
      phi52_r <= phi51_r;
      st52_r  <= st51_r;
      if (lim_hi) begin
        slope_r <= 32'sh7fffffff;
      end else if (lim_lo) begin
        slope_r <= 32'sh80000000;
      end else begin
        slope_r <= lim[tsl_pkg::DW-1:0];
      end
      phi_o_r <= phi52_r;
      sat_o_r <= st52_r || lim_hi || lim_lo;
    end
  end

  assign out_ch.limited_slope = slope_r;
  assign out_ch.limiter_value = phi_o_r;
  assign out_ch.saturated     = sat_o_r;

endmodule

// ===== tb/tb_tvd_slope_limiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TVD slope limiter testbench
// Drives cell-value beats through the limiter under several bias and mode
// settings, takes each expected beat from a fixed-point model or the directed table and checks each field.
// ----------------------------------------------------------------------------
module tb_tvd_slope_limiter;

  localparam int LATENCY = 53;

  typedef struct packed {
    logic signed [31:0] slope;
    logic [15:0]        phi;
    logic               sat;
  } lim_res_t;

  typedef struct {
    logic signed [31:0] l, m, r;
    bit                 known;
    lim_res_t           res;
  } cell_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tsl_in_if  in_ch();
  tsl_out_if out_ch();
  tsl_cfg_if cfg_ch();

  tvd_slope_limiter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [15:0] bias_q;
  logic [1:0]         mode_q;
  lim_res_t           pending[$];
  int                 n_err = 0;
  int                 src_idle = 0;
  int                 snk_stall = 0;
  int                 hold_cycles = 0;

  // Reciprocal term of the limiter, capped at two.
  function automatic longint xi_q14(longint r, longint w);
    longint d;
    longint q;
    d = (16384 - w) * 16384 + (16384 + w) * r;
    if (d <= 0) return 32768;
    q = (64'sd1 <<< 43) / d;
    return (q > 32768) ? 32768 : q;
  endfunction

  function automatic longint fl_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic lim_res_t limit_slope(logic signed [31:0] l, logic signed [31:0] m,
                                           logic signed [31:0] rv);
    lim_res_t res;
    longint w, dl, dr, s, num, den, an, ad, mag, r, phi, lim, vl;
    bit sat;
    w = bias_q;
    if (w > 16384) w = 16384;
    if (w < -16384) w = -16384;
    sat = 0;
    dl = longint'(m) - longint'(l);
    dr = longint'(rv) - longint'(m);
    s = fl_shr((16384 + w) * dl + (16384 - w) * dr + 16384, 15);
    num = (dl > 1 || dl < -1) ? dl : 1;
    den = (dr > 1 || dr < -1) ? dr : 1;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    mag = (an <<< 14) / ad;
    if (mag > 1073741824) begin
      mag = 1073741824;
      sat = 1;
    end
    r = ((num < 0) != (den < 0)) ? -mag : mag;
    if (r < 0) begin
      phi = 0;
    end else if (mode_q == tsl_pkg::MODE_SUPERBEE) begin
      if (r < 8192) phi = 2 * r;
      else if (r < 16384) phi = 16384;
      else begin
        phi = xi_q14(r, w);
        if (r < phi) phi = r;
        if (phi > 32768) phi = 32768;
      end
    end else if (mode_q == tsl_pkg::MODE_VANLEER) begin
      vl = (2 * r * 16384) / (16384 + r);
      phi = xi_q14(r, w);
      if (vl < phi) phi = vl;
    end else begin
      if (r < 16384) phi = r;
      else begin
        phi = xi_q14(r, w);
        if (phi > 16384) phi = 16384;
      end
    end
    lim = fl_shr(s * phi + 8192, 14);
    if (lim > 64'sd2147483647) begin
      lim = 64'sd2147483647;
      sat = 1;
    end else if (lim < -64'sd2147483648) begin
      lim = -64'sd2147483648;
      sat = 1;
    end
    res.slope = lim[31:0];
    res.phi = phi[15:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic write_reg(input logic [tsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == tsl_pkg::CFG_BIAS) bias_q = val;
    else if (idx == tsl_pkg::CFG_MODE) mode_q = val[1:0];
    @(posedge clk);
  endtask

  // Idle point: wait for every result, then let the pipeline drain.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // The input valid stays high after a beat; idle cycles and callers drop it.
  task automatic send_cells(input logic signed [31:0] l, input logic signed [31:0] m,
                            input logic signed [31:0] rv);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_value   <= l;
    in_ch.middle_value <= m;
    in_ch.right_value  <= rv;
    do @(posedge clk); while (!in_ch.ready);
    pending.push_back(limit_slope(l, m, rv));
  endtask

  function automatic logic signed [31:0] rand_val(int kind);
    unique case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(2000)) - 1000;
      default: return $signed($urandom_range(600000)) - 300000;
    endcase
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    lim_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat slope=%0d", out_ch.limited_slope);
      end else begin
        exp_r = pending.pop_front();
        if (exp_r.slope !== out_ch.limited_slope || exp_r.phi !== out_ch.limiter_value ||
            exp_r.sat !== out_ch.saturated) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp slope=%0d phi=%0d sat=%0b got slope=%0d phi=%0d sat=%0b",
                     exp_r.slope, exp_r.phi, exp_r.sat, out_ch.limited_slope,
                     out_ch.limiter_value, out_ch.saturated);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  cell_row_t dir_rows[$];
  int        mode_set[4] = '{0, 1, 2, 3};
  logic [15:0] bias_set[6] = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd8000, 16'sd32767,
                               -16'sd32768};

  initial begin
    cell_row_t row;
    lim_res_t  zero_res;
    int        k;
    in_ch.valid = 1'b0;
    in_ch.left_value = '0;
    in_ch.middle_value = '0;
    in_ch.right_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    bias_q = 0;
    mode_q = tsl_pkg::MODE_SUPERBEE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; flat input gives zero slope and a phi of one after reset.
    zero_res = '{slope: 0, phi: 0, sat: 1'b0};
    dir_rows.push_back('{l: 0, m: 0, r: 0, known: 1, res: '{0, 16'd16384, 1'b0}});
    dir_rows.push_back('{l: 5, m: 5, r: 5, known: 1, res: '{0, 16'd16384, 1'b0}});
    dir_rows.push_back('{l: 0, m: 10, r: 0, known: 1, res: zero_res});
    dir_rows.push_back('{l: 32'sh80000000, m: 32'sh7fffffff, r: 32'sh7fffffff,
                         known: 0, res: zero_res});
    dir_rows.push_back('{l: 32'sh7fffffff, m: 32'sh80000000, r: 32'sh80000000,
                         known: 0, res: zero_res});
    dir_rows.push_back('{l: 32'sh80000000, m: 0, r: 32'sh7fffffff, known: 0, res: zero_res});
    dir_rows.push_back('{l: 32'sh7fffffff, m: 0, r: 32'sh80000000, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 1, r: 2, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: -1, r: -2, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 100, r: 101, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 100, r: 130, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 100, r: 180, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 100, r: 300, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 100, r: 1000, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: -100, r: 50, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 1000, r: 1200, known: 0, res: zero_res});
    dir_rows.push_back('{l: 0, m: 1, r: 100000, known: 0, res: zero_res});
    dir_rows.push_back('{l: -5, m: 0, r: 0, known: 0, res: zero_res});

    // Walk the table under each mode, and again with the bias at its extremes.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(tsl_pkg::CFG_MODE, 16'(mode_set[ph % 4]));
        write_reg(tsl_pkg::CFG_BIAS, bias_set[ph]);
      end
      foreach (dir_rows[i]) begin
        send_cells(dir_rows[i].l, dir_rows[i].m, dir_rows[i].r);
        if (dir_rows[i].known && ph == 0) begin
          pending.pop_back();
          pending.push_back(dir_rows[i].res);
        end
      end
    end

    // Random part in phases of idling and configuration.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(tsl_pkg::CFG_BIAS, (ph % 3 == 0) ? bias_set[$urandom_range(5)]
                                   : 16'($signed($urandom_range(32768)) - 16384));
      write_reg(tsl_pkg::CFG_MODE, 16'($urandom_range(3)));
      unique case (ph % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 57; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 57; end
        default: begin src_idle = 38; snk_stall = 38; end
      endcase
      if (ph == 4) hold_cycles = 300;
      for (int i = 0; i < 120; i++) begin
        k = $urandom_range(2);
        send_cells(rand_val(k), rand_val(k), rand_val(k));
        // Pause the sender until everything is back once.
        if (ph == 5 && i == 60) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk); while (pending.size() != 0);
        end
      end
    end

    in_ch.valid <= 1'b0;
    src_idle = 0;
    snk_stall = 0;
    k = 0;
    while (pending.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (n_err == 0 && pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== tvd_slope_limiter.f =====
hw/rtl/tsl_pkg.sv
hw/rtl/tsl_if.sv
hw/rtl/tsl_rdiv.sv
hw/rtl/tsl_qdiv.sv
hw/rtl/tvd_slope_limiter.sv
tb/tb_tvd_slope_limiter.sv
